// ----- hw/rtl/i2cmw_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Types and codes shared by the I2C master write engine modules.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_BEGIN = 2'd1;
    localparam op_t OP_QUEUE = 2'd2;
    localparam op_t OP_NOP   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_BIT_SET   = 4'd3,
        PH_BIT_RISE  = 4'd4,
        PH_BIT_WAIT  = 4'd5,
        PH_ACK_REL   = 4'd6,
        PH_ACK_RISE  = 4'd7,
        PH_ACK_WAIT  = 4'd8,
        PH_ACK_SDA   = 4'd9,
        PH_HOLD      = 4'd10,
        PH_STOP_REL  = 4'd11,
        PH_STOP_WAIT = 4'd12
    } phase_t;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        op_t        op;
        logic [6:0] target_address;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       scl_sampled;
        logic       sda_sampled;
    } i2cmw_req_t;

    typedef struct packed {
        logic scl_low;
        logic sda_low;
        logic busy_res;
        logic want_byte;
        logic ack_valid;
        logic ack_level;
        logic done_res;
    } i2cmw_rsp_t;

endpackage

// ----- hw/rtl/i2cmw_core.sv -----
// ----------------------------------------------------------------------------
// i2cmw_core
// Line-step sequencer: updates the engine state on each accepted word and
// forms that word's result.
// ----------------------------------------------------------------------------
module i2cmw_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  i2cmw_pkg::i2cmw_req_t req,
    output i2cmw_pkg::i2cmw_rsp_t rsp
);
    import i2cmw_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic        final_reg, final_next;
    logic [7:0]  queued_byte_reg;
    logic        queued_valid_reg, queued_valid_next;
    logic        queued_last_reg, queued_last_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;

    logic        tick;
    logic        cur_bit;

    assign tick    = accept && (req.op == OP_TICK);
    assign cur_bit = shift_reg[3'd7 - bit_index_reg[2:0]];

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        shift_next        = shift_reg;
        final_next        = final_reg;
        queued_valid_next = queued_valid_reg;
        queued_last_next  = queued_last_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        if (accept)
        begin
            unique case (req.op)
                OP_BEGIN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        shift_next     = {req.target_address, 1'b0};
                        final_next     = req.last_byte;
                        bit_index_next = '0;
                        phase_next     = PH_START_A;
                    end
                end
                OP_QUEUE:
                begin
                    queued_last_next  = req.last_byte;
                    queued_valid_next = 1'b1;
                end
                OP_TICK:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            scl_next = 1'b0;
                            sda_next = 1'b0;
                        end
                        PH_START_A:
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_START_B;
                        end
                        PH_START_B:
                        begin
                            scl_next       = 1'b1;
                            bit_index_next = '0;
                            phase_next     = PH_BIT_SET;
                        end
                        PH_BIT_SET:
                        begin
                            sda_next   = ~cur_bit;
                            phase_next = PH_BIT_RISE;
                        end
                        PH_BIT_RISE:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_BIT_WAIT;
                        end
                        PH_BIT_WAIT:
                        begin
                            // clock stretching: hold until SCL reads high
                            if (req.scl_sampled)
                            begin
                                scl_next       = 1'b1;
                                bit_index_next = bit_index_reg + 4'd1;
                                phase_next     = (bit_index_next >= BITS_PER_BYTE)
                                                 ? PH_ACK_REL : PH_BIT_SET;
                            end
                        end
                        PH_ACK_REL:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_ACK_RISE;
                        end
                        PH_ACK_RISE:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_ACK_WAIT;
                        end
                        PH_ACK_WAIT:
                        begin
                            if (req.scl_sampled)
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_ACK_SDA;
                            end
                        end
                        PH_ACK_SDA:
                        begin
                            sda_next = 1'b1;
                            if (final_reg)
                            begin
                                phase_next = PH_STOP_REL;
                            end
                            else if (queued_valid_reg)
                            begin
                                shift_next        = queued_byte_reg;
                                final_next        = queued_last_reg;
                                queued_valid_next = 1'b0;
                                bit_index_next    = '0;
                                phase_next        = PH_BIT_SET;
                            end
                            else
                            begin
                                phase_next = PH_HOLD;
                            end
                        end
                        PH_HOLD:
                        begin
                            // load and drive msb of the queued byte in one step
                            if (queued_valid_reg)
                            begin
                                shift_next        = queued_byte_reg;
                                final_next        = queued_last_reg;
                                queued_valid_next = 1'b0;
                                bit_index_next    = '0;
                                sda_next          = ~queued_byte_reg[7];
                                phase_next        = PH_BIT_RISE;
                            end
                        end
                        PH_STOP_REL:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_STOP_WAIT;
                        end
                        PH_STOP_WAIT:
                        begin
                            if (req.scl_sampled)
                            begin
                                sda_next       = 1'b0;
                                bit_index_next = '0;
                                final_next     = 1'b0;
                                phase_next     = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // result outputs
    always_comb
    begin
        rsp.scl_low   = scl_next;
        rsp.sda_low   = sda_next;
        rsp.busy_res  = (phase_next != PH_IDLE);
        rsp.want_byte = (phase_next != PH_IDLE) && !final_next && !queued_valid_next;
        rsp.ack_valid = tick && (phase_reg == PH_ACK_WAIT) && req.scl_sampled;
        rsp.ack_level = rsp.ack_valid && req.sda_sampled;
        rsp.done_res  = tick && (phase_reg == PH_STOP_WAIT) && req.scl_sampled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= '0;
            shift_reg        <= '0;
            final_reg        <= 1'b0;
            queued_valid_reg <= 1'b0;
            queued_last_reg  <= 1'b0;
            scl_reg          <= 1'b0;
            sda_reg          <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            shift_reg        <= shift_next;
            final_reg        <= final_next;
            queued_valid_reg <= queued_valid_next;
            queued_last_reg  <= queued_last_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
        end
    end

    // queued byte holds no value until the first queue word
    always_ff @(posedge clk)
    begin
        if (accept && (req.op == OP_QUEUE))
        begin
            queued_byte_reg <= req.data_byte;
        end
    end

endmodule

// ----- hw/rtl/i2c_master_write_engine_top.sv -----
// Result: registered; each accepted word's result leaves through the output buffer.
// Throughput: one word per cycle while req_stall is low; each tick word is one line step of the
// sequencer, and a two-entry output buffer keeps the input open while
// one result waits.
// Reset: asynchronous, active low; engine idle with both lines released,
// no byte queued, output buffer empty.
// ----------------------------------------------------------------------------
// i2c_master_write_engine_top
// Write-only open-drain I2C master with clock stretching, one step per tick.
// ----------------------------------------------------------------------------
module i2c_master_write_engine_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  i2cmw_pkg::i2cmw_req_t req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output i2cmw_pkg::i2cmw_rsp_t rsp
);
    import i2cmw_pkg::*;

    logic       accept;
    i2cmw_rsp_t result;
    logic       out_valid_reg;
    i2cmw_rsp_t out_reg;
    logic       skid_valid_reg;
    i2cmw_rsp_t skid_reg;
    logic       out_free;

    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    i2cmw_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .rsp    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        if (accept && !out_free)
        begin
            skid_reg <= result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- hw/rtl/i2cmw_checker.sv -----
// ----------------------------------------------------------------------------
// i2cmw_checker
// Port-level checks for the I2C master write engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmw_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rsp_valid,
    input logic                  rsp_stall,
    input i2cmw_pkg::i2cmw_rsp_t rsp
);
    import i2cmw_pkg::*;

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    a_want_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.want_byte |-> rsp.busy_res)
        else $error("want_byte while idle");

    a_ack_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ack_valid |-> !rsp.ack_level)
        else $error("ack_level without ack_valid");

    // STOP completes with the engine idle and both lines released
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.done_res |-> !rsp.busy_res && !rsp.scl_low && !rsp.sda_low)
        else $error("done with engine busy or a line driven");

    a_ack_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ack_valid |-> rsp.busy_res && !rsp.done_res)
        else $error("ack reported outside a transfer");

endmodule

bind i2c_master_write_engine_top i2cmw_checker u_i2cmw_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
